@@ rtl/slxfr_pkg.sv @@
// ----------------------------------------------------------------------------
// slxfr_pkg
// Shared types and constants of the sync/length/XOR frame receiver.
// ----------------------------------------------------------------------------
package slxfr_pkg;

    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned LEN_W      = 5;
    localparam int unsigned INDEX_W    = 4;
    localparam int unsigned CHAN_W     = 3;
    localparam int unsigned CFG_IDX_W  = 1;

    localparam logic [CFG_IDX_W-1:0] REG_SYNC_VALUE  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_PAYLOAD = 1'd1;

    localparam logic [BYTE_W-1:0] SYNC_RESET   = 8'hA4;
    localparam logic [LEN_W-1:0]  MAX_RESET    = 5'd16;
    localparam logic [BYTE_W-1:0] CHAN_MASK    = 8'h07;

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_LENGTH,
        PH_ID,
        PH_DATA,
        PH_CHECK
    } t_phase;

    typedef struct packed {
        logic              bank;
        logic [BYTE_W-1:0] id;
        logic [LEN_W-1:0]  len;
        logic [CHAN_W-1:0] chan;
    } t_desc;

endpackage

@@ rtl/slxfr_ram.sv @@
// ----------------------------------------------------------------------------
// slxfr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module slxfr_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/slxfr_front.sv @@
// ----------------------------------------------------------------------------
// slxfr_front
// Frame parser: hunts for sync, checks length, buffers payload, checks XOR.
// ----------------------------------------------------------------------------
module slxfr_front #(
    parameter int unsigned MAX_PAYLOAD_BYTES = 16
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       i_cfg_we,
    input  logic [slxfr_pkg::CFG_IDX_W-1:0]            i_cfg_index,
    input  logic [slxfr_pkg::BYTE_W-1:0]               i_cfg_data,
    input  logic                                       i_valid,
    input  logic [slxfr_pkg::BYTE_W-1:0]               i_rx_byte,
    output logic                                       o_ram_we,
    output logic [$clog2(2*MAX_PAYLOAD_BYTES)-1:0]     o_ram_waddr,
    output logic [slxfr_pkg::BYTE_W-1:0]               o_ram_wdata,
    output logic                                       o_desc_push,
    output slxfr_pkg::t_desc                           o_desc
);

    localparam int unsigned AW    = $clog2(2 * MAX_PAYLOAD_BYTES);
    localparam int unsigned IDX_W = (MAX_PAYLOAD_BYTES > 1) ? $clog2(MAX_PAYLOAD_BYTES) : 1;
    localparam logic [AW-1:0] BANK_OFFSET = AW'(MAX_PAYLOAD_BYTES);
    localparam logic [5:0]    MAX_BYTES   = 6'(MAX_PAYLOAD_BYTES);

    slxfr_pkg::t_phase r_phase, n_phase;
    logic [slxfr_pkg::BYTE_W-1:0] r_sync, r_xor, n_xor, r_id, n_id;
    logic [slxfr_pkg::LEN_W-1:0]  r_max, r_len, n_len, r_cnt, n_cnt;
    logic [slxfr_pkg::CHAN_W-1:0] r_chan, n_chan;
    logic                         r_bank, n_bank;
    logic [5:0]                   eff_max;
    logic                         len_ok;
    logic [AW-1:0]                idx_addr;

    assign eff_max  = ({1'b0, r_max} > MAX_BYTES) ? MAX_BYTES : {1'b0, r_max};
    assign len_ok   = (i_rx_byte != '0) && (i_rx_byte <= {2'b00, eff_max});
    assign idx_addr = AW'(r_cnt[IDX_W-1:0]);

    assign o_ram_waddr = r_bank ? (BANK_OFFSET + idx_addr) : idx_addr;
    assign o_ram_wdata = i_rx_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync <= slxfr_pkg::SYNC_RESET;
            r_max  <= slxfr_pkg::MAX_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                slxfr_pkg::REG_SYNC_VALUE:  r_sync <= i_cfg_data;
                slxfr_pkg::REG_MAX_PAYLOAD: r_max  <= i_cfg_data[slxfr_pkg::LEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= slxfr_pkg::PH_HUNT;
            r_xor   <= slxfr_pkg::SYNC_RESET;
            r_len   <= '0;
            r_cnt   <= '0;
            r_id    <= '0;
            r_chan  <= '0;
            r_bank  <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_xor   <= n_xor;
            r_len   <= n_len;
            r_cnt   <= n_cnt;
            r_id    <= n_id;
            r_chan  <= n_chan;
            r_bank  <= n_bank;
        end
    end

    always_comb begin
        n_phase     = r_phase;
        n_xor       = r_xor;
        n_len       = r_len;
        n_cnt       = r_cnt;
        n_id        = r_id;
        n_chan      = r_chan;
        n_bank      = r_bank;
        o_ram_we    = 1'b0;
        o_desc_push = 1'b0;
        o_desc      = '{bank: r_bank, id: r_id, len: r_len, chan: r_chan};
        if (i_valid) begin
            unique case (r_phase)
                slxfr_pkg::PH_LENGTH: begin
                    if (!len_ok) begin
                        n_phase = slxfr_pkg::PH_HUNT;
                    end else begin
                        n_xor   = r_xor ^ i_rx_byte;
                        n_len   = i_rx_byte[slxfr_pkg::LEN_W-1:0];
                        n_cnt   = '0;
                        n_phase = slxfr_pkg::PH_ID;
                    end
                end
                slxfr_pkg::PH_ID: begin
                    n_id    = i_rx_byte;
                    n_xor   = r_xor ^ i_rx_byte;
                    n_phase = slxfr_pkg::PH_DATA;
                end
                slxfr_pkg::PH_DATA: begin
                    o_ram_we = 1'b1;
                    if (r_cnt == '0) begin
                        n_chan = slxfr_pkg::CHAN_W'(i_rx_byte & slxfr_pkg::CHAN_MASK);
                    end
                    n_xor = r_xor ^ i_rx_byte;
                    n_cnt = r_cnt + 1'b1;
                    if (n_cnt >= r_len) begin
                        n_phase = slxfr_pkg::PH_CHECK;
                    end
                end
                slxfr_pkg::PH_CHECK: begin
                    if (r_xor == i_rx_byte) begin
                        o_desc_push = 1'b1;
                        n_bank      = ~r_bank;
                    end
                    n_phase = slxfr_pkg::PH_HUNT;
                end
                default: begin
                    if (i_rx_byte == r_sync) begin
                        n_xor   = r_sync;
                        n_phase = slxfr_pkg::PH_LENGTH;
                    end else begin
                        n_phase = slxfr_pkg::PH_HUNT;
                    end
                end
            endcase
        end
    end

endmodule

@@ rtl/slxfr_queue.sv @@
// ----------------------------------------------------------------------------
// slxfr_queue
// Two-entry queue of frame descriptors between parser and emitter.
// ----------------------------------------------------------------------------
module slxfr_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  slxfr_pkg::t_desc i_desc,
    input  logic             i_pop,
    output slxfr_pkg::t_desc o_head,
    output logic             o_empty,
    output logic             o_full
);

    slxfr_pkg::t_desc r_q [2];
    logic             r_rd_ptr, r_wr_ptr;
    logic [1:0]       r_count, n_count;

    assign o_head  = r_q[r_rd_ptr];
    assign o_empty = (r_count == 2'd0);
    assign o_full  = (r_count == 2'd2);

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 2'd1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wr_ptr] <= i_desc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ptr <= 1'b0;
            r_wr_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= n_count;
        end
    end

endmodule

@@ rtl/slxfr_back.sv @@
// ----------------------------------------------------------------------------
// slxfr_back
// Emitter: walks a buffered frame and presents one payload word at a time.
// ----------------------------------------------------------------------------
module slxfr_back #(
    parameter int unsigned MAX_PAYLOAD_BYTES = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  slxfr_pkg::t_desc                       i_head,
    input  logic                                   i_q_empty,
    output logic                                   o_q_pop,
    output logic                                   o_ram_re,
    output logic [$clog2(2*MAX_PAYLOAD_BYTES)-1:0] o_ram_raddr,
    input  logic [slxfr_pkg::BYTE_W-1:0]           i_ram_rdata,
    input  logic                                   i_pop,
    output logic                                   o_empty,
    output logic [slxfr_pkg::BYTE_W-1:0]           o_message_id,
    output logic [slxfr_pkg::BYTE_W-1:0]           o_payload_byte,
    output logic [slxfr_pkg::INDEX_W-1:0]          o_byte_index,
    output logic [slxfr_pkg::LEN_W-1:0]            o_payload_length,
    output logic [slxfr_pkg::CHAN_W-1:0]           o_channel,
    output logic                                   o_last_of_frame
);

    localparam int unsigned AW    = $clog2(2 * MAX_PAYLOAD_BYTES);
    localparam int unsigned IDX_W = (MAX_PAYLOAD_BYTES > 1) ? $clog2(MAX_PAYLOAD_BYTES) : 1;
    localparam logic [AW-1:0] BANK_OFFSET = AW'(MAX_PAYLOAD_BYTES);

    logic [slxfr_pkg::LEN_W-1:0]   r_idx;
    logic                          r_pend;
    logic                          r_out_valid;
    logic [slxfr_pkg::BYTE_W-1:0]  r_pend_id, r_out_id, r_out_byte;
    logic [slxfr_pkg::INDEX_W-1:0] r_pend_index, r_out_index;
    logic [slxfr_pkg::LEN_W-1:0]   r_pend_len, r_out_len;
    logic [slxfr_pkg::CHAN_W-1:0]  r_pend_chan, r_out_chan;
    logic                          r_pend_last, r_out_last;
    logic                          issue, is_last;
    logic [AW-1:0]                 idx_addr;

    assign issue    = !i_q_empty && !r_pend && (!r_out_valid || i_pop);
    assign is_last  = ((r_idx + 1'b1) == i_head.len);
    assign idx_addr = AW'(r_idx[IDX_W-1:0]);

    assign o_ram_re    = issue;
    assign o_ram_raddr = i_head.bank ? (BANK_OFFSET + idx_addr) : idx_addr;
    assign o_q_pop     = issue && is_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (issue) begin
                r_idx <= is_last ? '0 : r_idx + 1'b1;
            end
            r_pend <= issue;
            if (r_pend) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_pend_id    <= i_head.id;
            r_pend_index <= r_idx[slxfr_pkg::INDEX_W-1:0];
            r_pend_len   <= i_head.len;
            r_pend_chan  <= i_head.chan;
            r_pend_last  <= is_last;
        end
        if (r_pend) begin
            r_out_id    <= r_pend_id;
            r_out_byte  <= i_ram_rdata;
            r_out_index <= r_pend_index;
            r_out_len   <= r_pend_len;
            r_out_chan  <= r_pend_chan;
            r_out_last  <= r_pend_last;
        end
    end

    assign o_empty          = !r_out_valid;
    assign o_message_id     = r_out_id;
    assign o_payload_byte   = r_out_byte;
    assign o_byte_index     = r_out_index;
    assign o_payload_length = r_out_len;
    assign o_channel        = r_out_chan;
    assign o_last_of_frame  = r_out_last;

endmodule

@@ rtl/sync_length_xor_frame_receiver.sv @@
// ----------------------------------------------------------------------------
// sync_length_xor_frame_receiver
// Serial frame receiver with sync, length, id, payload and XOR checksum.
// ----------------------------------------------------------------------------
// Takes one received byte per cycle while not full. A parser hunts for the sync
// byte, checks the length, buffers the payload into one of two frame banks of a
// RAM and compares the checksum; a good frame is handed to the emitter through a
// two-entry descriptor queue, a bad one is dropped. Input is refused (full)
// only while both banks hold frames whose last payload word has not yet been
// read out. The emitter issues a read of the frame RAM only after the previous
// read has returned, and only while its output word is free or being popped.
// Configuration writes are always ready and apply from the next byte.
module sync_length_xor_frame_receiver #(
    parameter int unsigned MAX_PAYLOAD_BYTES = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [slxfr_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [slxfr_pkg::BYTE_W-1:0]        i_cfg_data,
    input  logic                                push,
    output logic                                full,
    input  logic [slxfr_pkg::BYTE_W-1:0]        i_rx_byte,
    output logic                                empty,
    input  logic                                pop,
    output logic [slxfr_pkg::BYTE_W-1:0]        o_message_id,
    output logic [slxfr_pkg::BYTE_W-1:0]        o_payload_byte,
    output logic [slxfr_pkg::INDEX_W-1:0]       o_byte_index,
    output logic [slxfr_pkg::LEN_W-1:0]         o_payload_length,
    output logic [slxfr_pkg::CHAN_W-1:0]        o_channel,
    output logic                                o_last_of_frame
);

    localparam int unsigned DEPTH = 2 * MAX_PAYLOAD_BYTES;
    localparam int unsigned AW    = $clog2(DEPTH);

    logic                         q_full, q_empty, q_pop, desc_push;
    logic                         ram_we, ram_re;
    logic [AW-1:0]                ram_waddr, ram_raddr;
    logic [slxfr_pkg::BYTE_W-1:0] ram_wdata, ram_rdata;
    slxfr_pkg::t_desc             desc_in, desc_head;

    assign o_cfg_ready = 1'b1;
    assign full        = q_full;

    slxfr_front #(
        .MAX_PAYLOAD_BYTES(MAX_PAYLOAD_BYTES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (push && !q_full),
        .i_rx_byte   (i_rx_byte),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .o_desc_push (desc_push),
        .o_desc      (desc_in)
    );

    slxfr_ram #(
        .WIDTH(slxfr_pkg::BYTE_W),
        .DEPTH(DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    slxfr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (desc_push),
        .i_desc  (desc_in),
        .i_pop   (q_pop),
        .o_head  (desc_head),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    slxfr_back #(
        .MAX_PAYLOAD_BYTES(MAX_PAYLOAD_BYTES)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_head           (desc_head),
        .i_q_empty        (q_empty),
        .o_q_pop          (q_pop),
        .o_ram_re         (ram_re),
        .o_ram_raddr      (ram_raddr),
        .i_ram_rdata      (ram_rdata),
        .i_pop            (pop),
        .o_empty          (empty),
        .o_message_id     (o_message_id),
        .o_payload_byte   (o_payload_byte),
        .o_byte_index     (o_byte_index),
        .o_payload_length (o_payload_length),
        .o_channel        (o_channel),
        .o_last_of_frame  (o_last_of_frame)
    );

endmodule

@@ test/sync_length_xor_frame_receiver_tb.sv @@
// ----------------------------------------------------------------------------
// sync_length_xor_frame_receiver_tb
// Self-checking bench for the sync/length/XOR frame receiver.
// ----------------------------------------------------------------------------
// A driver feeds received bytes from a queue and a monitor pops payload words
// with random gaps on both sides. Every accepted byte runs through a local
// frame parser that queues the payload words a good frame must produce; each
// popped word is compared field by field with the oldest of them. Directed
// frames cover the field extremes, bad lengths and a bad checksum; random
// phases follow under several register settings, mostly well-formed frames
// mixed with broken ones and noise.
// ----------------------------------------------------------------------------
module sync_length_xor_frame_receiver_tb;

    localparam int unsigned STORE_DEPTH   = 16;
    localparam int unsigned SETTLE_CYCLES = 64;
    localparam int unsigned STALL_LIMIT   = 2000;

    localparam int FILL_RANDOM = 0;
    localparam int FILL_ZERO   = 1;
    localparam int FILL_ONES   = 2;

    typedef struct packed {
        logic [slxfr_pkg::BYTE_W-1:0]  id;
        logic [slxfr_pkg::BYTE_W-1:0]  data;
        logic [slxfr_pkg::INDEX_W-1:0] index;
        logic [slxfr_pkg::LEN_W-1:0]   length;
        logic [slxfr_pkg::CHAN_W-1:0]  chan;
        logic                          last;
    } t_payload_word;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_cfg_valid = 1'b0;
    logic                            o_cfg_ready;
    logic [slxfr_pkg::CFG_IDX_W-1:0] i_cfg_index = slxfr_pkg::REG_SYNC_VALUE;
    logic [slxfr_pkg::BYTE_W-1:0]    i_cfg_data = '0;
    logic                            push = 1'b0;
    logic                            full;
    logic [slxfr_pkg::BYTE_W-1:0]    i_rx_byte = '0;
    logic                            empty;
    logic                            pop = 1'b0;
    logic [slxfr_pkg::BYTE_W-1:0]    o_message_id;
    logic [slxfr_pkg::BYTE_W-1:0]    o_payload_byte;
    logic [slxfr_pkg::INDEX_W-1:0]   o_byte_index;
    logic [slxfr_pkg::LEN_W-1:0]     o_payload_length;
    logic [slxfr_pkg::CHAN_W-1:0]    o_channel;
    logic                            o_last_of_frame;

    sync_length_xor_frame_receiver #(
        .MAX_PAYLOAD_BYTES(STORE_DEPTH)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .push            (push),
        .full            (full),
        .i_rx_byte       (i_rx_byte),
        .empty           (empty),
        .pop             (pop),
        .o_message_id    (o_message_id),
        .o_payload_byte  (o_payload_byte),
        .o_byte_index    (o_byte_index),
        .o_payload_length(o_payload_length),
        .o_channel       (o_channel),
        .o_last_of_frame (o_last_of_frame)
    );

    logic [slxfr_pkg::BYTE_W-1:0] rx_pending[$];
    t_payload_word                payload_words[$];

    int rx_sent = 0;
    int rx_taken = 0;
    int rx_gap_left = 0;
    bit rx_calm = 1'b0;
    int word_taken = 0;
    int word_seen = 0;
    int word_gap_left = 0;
    bit word_calm = 1'b0;
    int stall_cycles = 0;
    int error_count = 0;

    logic [slxfr_pkg::BYTE_W-1:0] cfg_sync = slxfr_pkg::SYNC_RESET;
    logic [slxfr_pkg::LEN_W-1:0]  cfg_max = slxfr_pkg::MAX_RESET;

    slxfr_pkg::t_phase            prs_phase = slxfr_pkg::PH_HUNT;
    logic [slxfr_pkg::BYTE_W-1:0] prs_xor = slxfr_pkg::SYNC_RESET;
    logic [slxfr_pkg::LEN_W-1:0]  prs_length = '0;
    int                           prs_count = 0;
    logic [slxfr_pkg::BYTE_W-1:0] prs_id = '0;
    logic [slxfr_pkg::BYTE_W-1:0] prs_store [STORE_DEPTH];

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic int length_limit();
        return (cfg_max > STORE_DEPTH) ? int'(STORE_DEPTH) : int'(cfg_max);
    endfunction

    task automatic parse_rx_byte(input logic [slxfr_pkg::BYTE_W-1:0] b);
        t_payload_word w;
        case (prs_phase)
            slxfr_pkg::PH_LENGTH: begin
                if (b == 0 || int'(b) > length_limit()) begin
                    prs_phase = slxfr_pkg::PH_HUNT;
                end else begin
                    prs_xor    = prs_xor ^ b;
                    prs_length = b[slxfr_pkg::LEN_W-1:0];
                    prs_count  = 0;
                    prs_phase  = slxfr_pkg::PH_ID;
                end
            end
            slxfr_pkg::PH_ID: begin
                prs_id    = b;
                prs_xor   = prs_xor ^ b;
                prs_phase = slxfr_pkg::PH_DATA;
            end
            slxfr_pkg::PH_DATA: begin
                if (prs_count < STORE_DEPTH)
                    prs_store[prs_count] = b;
                prs_xor   = prs_xor ^ b;
                prs_count = (prs_count + 1) % 64;
                if (prs_count >= prs_length)
                    prs_phase = slxfr_pkg::PH_CHECK;
            end
            slxfr_pkg::PH_CHECK: begin
                if (prs_xor == b) begin
                    for (int i = 0; i < prs_length; i++) begin
                        w.id     = prs_id;
                        w.data   = prs_store[i];
                        w.index  = i[slxfr_pkg::INDEX_W-1:0];
                        w.length = prs_length;
                        w.chan   = prs_store[0][slxfr_pkg::CHAN_W-1:0];
                        w.last   = (i + 1 == prs_length);
                        payload_words.push_back(w);
                    end
                end
                prs_phase = slxfr_pkg::PH_HUNT;
            end
            default: begin
                if (b == cfg_sync) begin
                    prs_xor   = cfg_sync;
                    prs_phase = slxfr_pkg::PH_LENGTH;
                end else begin
                    prs_phase = slxfr_pkg::PH_HUNT;
                end
            end
        endcase
    endtask

    // Accepted bytes into the parser, payload words out, checked against the parser's queue; watchdog on stalls.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (push && !full) begin
                parse_rx_byte(i_rx_byte);
                rx_taken++;
            end
            if (pop && !empty) begin
                word_taken++;
                if (payload_words.size() == 0) begin
                    $error("unexpected payload word: id %0h byte %0h",
                           o_message_id, o_payload_byte);
                    error_count++;
                end else begin
                    t_payload_word w;
                    w = payload_words.pop_front();
                    if (o_message_id !== w.id) begin
                        $error("message_id expected %0h actual %0h", w.id, o_message_id);
                        error_count++;
                    end
                    if (o_payload_byte !== w.data) begin
                        $error("payload_byte expected %0h actual %0h",
                               w.data, o_payload_byte);
                        error_count++;
                    end
                    if (o_byte_index !== w.index) begin
                        $error("byte_index expected %0d actual %0d", w.index, o_byte_index);
                        error_count++;
                    end
                    if (o_payload_length !== w.length) begin
                        $error("payload_length expected %0d actual %0d",
                               w.length, o_payload_length);
                        error_count++;
                    end
                    if (o_channel !== w.chan) begin
                        $error("channel expected %0d actual %0d",
                               w.chan, o_channel);
                        error_count++;
                    end
                    if (o_last_of_frame !== w.last) begin
                        $error("last_of_frame expected %0b actual %0b",
                               w.last, o_last_of_frame);
                        error_count++;
                    end
                end
            end
            if ((push && !full) || (pop && !empty) || (i_cfg_valid && o_cfg_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // Byte driver: advance on acceptance, hold off for a random gap.
    always @(negedge i_clk) begin
        if (i_rst_n && (!push || rx_taken == rx_sent)) begin
            if (rx_gap_left != 0) begin
                push <= 1'b0;
                rx_gap_left--;
            end else if (rx_pending.size() != 0) begin
                i_rx_byte <= rx_pending.pop_front();
                push      <= 1'b1;
                rx_sent++;
                if ($urandom_range(0, 39) == 0)
                    rx_calm = !rx_calm;
                rx_gap_left = rx_calm ? 0 : $urandom_range(0, 19);
            end else begin
                push <= 1'b0;
            end
        end
    end

    // Word receiver: drop pop for a random gap after each accepted word.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (word_seen != word_taken) begin
                word_seen = word_taken;
                if ($urandom_range(0, 39) == 0)
                    word_calm = !word_calm;
                word_gap_left = word_calm ? 0 : $urandom_range(0, 19);
            end
            if (word_gap_left != 0) begin
                pop <= 1'b0;
                word_gap_left--;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    task automatic write_reg(input logic [slxfr_pkg::CFG_IDX_W-1:0] idx,
                             input logic [slxfr_pkg::BYTE_W-1:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == slxfr_pkg::REG_SYNC_VALUE)
            cfg_sync = value;
        else
            cfg_max = value[slxfr_pkg::LEN_W-1:0];
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic drain_frames();
        while (rx_pending.size() != 0 || rx_taken != rx_sent || payload_words.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic queue_frame(input int len, input logic [slxfr_pkg::BYTE_W-1:0] id,
                               input int fill, input bit bad_sum, input int cut);
        logic [slxfr_pkg::BYTE_W-1:0] sum;
        logic [slxfr_pkg::BYTE_W-1:0] b;
        sum = cfg_sync ^ len[slxfr_pkg::BYTE_W-1:0] ^ id;
        rx_pending.push_back(cfg_sync);
        rx_pending.push_back(len[slxfr_pkg::BYTE_W-1:0]);
        rx_pending.push_back(id);
        for (int i = 0; i < len - cut; i++) begin
            case (fill)
                FILL_ZERO: b = '0;
                FILL_ONES: b = '1;
                default:   b = 8'($urandom_range(0, 255));
            endcase
            sum = sum ^ b;
            rx_pending.push_back(b);
        end
        if (cut == 0) begin
            if (bad_sum)
                sum = sum ^ (8'h01 << $urandom_range(0, 7));
            rx_pending.push_back(sum);
        end
    endtask

    task automatic random_frames(input int target);
        int queued;
        int top;
        int len;
        int pick;
        int n;
        queued = 0;
        top = (cfg_max == 0) ? STORE_DEPTH : int'(cfg_max);
        while (queued < target) begin
            pick = $urandom_range(0, 99);
            len  = ($urandom_range(0, 3) == 0) ? $urandom_range(1, top)
                                               : $urandom_range(1, (top < 4) ? top : 4);
            if (pick < 70) begin
                queue_frame(len, 8'($urandom_range(0, 255)), FILL_RANDOM, 1'b0, 0);
                queued += len + 4;
            end else if (pick < 80) begin
                queue_frame(len, 8'($urandom_range(0, 255)), FILL_RANDOM, 1'b1, 0);
                queued += len + 4;
            end else if (pick < 88) begin
                rx_pending.push_back(cfg_sync);
                if ($urandom_range(0, 1) == 0 || length_limit() == 255)
                    rx_pending.push_back(8'h00);
                else
                    rx_pending.push_back(8'($urandom_range(length_limit() + 1, 255)));
                queued += 2;
            end else if (pick < 94) begin
                n = $urandom_range(1, len);
                queue_frame(len, 8'($urandom_range(0, 255)), FILL_RANDOM, 1'b0, n);
                queued += len + 3 - n;
            end else begin
                repeat ($urandom_range(1, 3)) rx_pending.push_back(8'($urandom_range(0, 255)));
            end
        end
    endtask

    initial begin
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        queue_frame(1, 8'h00, FILL_ONES, 1'b0, 0);
        rx_pending.push_back(cfg_sync);
        rx_pending.push_back(8'h00);
        rx_pending.push_back(cfg_sync);
        rx_pending.push_back(cfg_sync);
        rx_pending.push_back(cfg_sync);
        rx_pending.push_back(8'h11);
        queue_frame(2, 8'hFF, FILL_ZERO, 1'b1, 0);
        queue_frame(3, 8'h5A, FILL_RANDOM, 1'b0, 0);
        drain_frames();

        queue_frame(16, 8'($urandom_range(0, 255)), FILL_RANDOM, 1'b0, 0);
        random_frames(80);
        rx_pending.push_back(cfg_sync);
        drain_frames();

        write_reg(slxfr_pkg::REG_MAX_PAYLOAD, 8'h01);
        write_reg(slxfr_pkg::REG_SYNC_VALUE, 8'h00);
        random_frames(50);
        drain_frames();

        write_reg(slxfr_pkg::REG_SYNC_VALUE, 8'hFF);
        write_reg(slxfr_pkg::REG_MAX_PAYLOAD, 8'hF0);
        random_frames(80);
        rx_pending.push_back(cfg_sync);
        drain_frames();

        write_reg(slxfr_pkg::REG_MAX_PAYLOAD, 8'hE0);
        write_reg(slxfr_pkg::REG_SYNC_VALUE, 8'($urandom_range(0, 255)));
        random_frames(20);
        drain_frames();

        write_reg(slxfr_pkg::REG_MAX_PAYLOAD, 8'hFF);
        random_frames(70);
        drain_frames();

        write_reg(slxfr_pkg::REG_SYNC_VALUE, 8'($urandom_range(0, 255)));
        write_reg(slxfr_pkg::REG_MAX_PAYLOAD, 8'($urandom_range(1, 16)));
        random_frames(90);
        drain_frames();

        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

@@ sync_length_xor_frame_receiver.f @@
rtl/slxfr_pkg.sv
rtl/slxfr_ram.sv
rtl/slxfr_front.sv
rtl/slxfr_queue.sv
rtl/slxfr_back.sv
rtl/sync_length_xor_frame_receiver.sv
test/sync_length_xor_frame_receiver_tb.sv
